// File: hw/rtl/circular_arc_angle_length_unit_defines.svh
// Assertion macros shared by the arc angle unit.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CIRCULAR_ARC_ANGLE_LENGTH_UNIT_DEFINES_SVH
`define CIRCULAR_ARC_ANGLE_LENGTH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAALU_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/caalu_pkg.sv
package caalu_pkg;

  // Default configuration.
  localparam int unsigned COORD_WIDTH_DEF  = 32;
  localparam int unsigned ANGLE_STAGES_DEF = 24;

  // Fixed datapath widths.
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned ANGLE_W    = 31;
  localparam int unsigned VEC_W      = 31;
  localparam int unsigned WIDE_W     = 64;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned QUO_W      = 34;
  localparam int unsigned DIV1_STEPS = 33;
  localparam int unsigned DIV2_STEPS = 34;
  localparam int unsigned CORD_W     = 35;
  localparam int unsigned ZED_W      = 33;

  // Angle constants in Q4.28 and unity in Q2.30.
  localparam logic [ANGLE_W-1:0] PI_Q28      = 31'd843314857;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q28 = 31'd421657428;
  localparam logic [ANGLE_W-1:0] TWO_PI_Q28  = 31'd1686629714;
  localparam logic [ANGLE_W-1:0] ONE_Q30     = 31'd1073741824;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] radius;
    logic               counter_clockwise;
  } in_t;

  typedef struct packed {
    logic [30:0]        arc_angle;
    logic signed [31:0] arc_length;
    logic               invalid;
  } out_t;

  // Item attributes that ride along the pipeline.
  typedef struct packed {
    logic signed [FIELD_W-1:0] radius;
    logic                      ccw;
    logic                      inv;
    logic                      dot_neg;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  // Rotation angle of one CORDIC step in Q4.28.
  function automatic logic [ZED_W-1:0] stage_angle(input int unsigned idx);
    logic [ZED_W-1:0] ang;
    case (idx)
      0:       ang = 33'd210828714;
      1:       ang = 33'd124459457;
      2:       ang = 33'd65760959;
      3:       ang = 33'd33381290;
      4:       ang = 33'd16755422;
      5:       ang = 33'd8385879;
      6:       ang = 33'd4193963;
      7:       ang = 33'd2097109;
      8:       ang = 33'd1048571;
      9:       ang = 33'd524287;
      default: begin
        if (idx <= 28) begin
          ang = ZED_W'(1) << (28 - idx);
        end else begin
          ang = '0;
        end
      end
    endcase
    return ang;
  endfunction

endpackage

// File: hw/rtl/circular_arc_angle_length_unit.sv
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  -------------------
// item      in         start_i high, busy_o low     item_i   (in_t)
// result    out        done_o strobe, one cycle     result_o (out_t)
//
// Fully pipelined: one item is taken every cycle and busy_o stays low.
// The pipeline is built from the three square root chains (32 cells each), the two
// divider chains (33 and 34 cells) and the CORDIC chain.
// Reset clears only the valid bits that travel with each item.
// The receiver cannot stall; each result shows for exactly one cycle.
`include "circular_arc_angle_length_unit_defines.svh"

module circular_arc_angle_length_unit #(
  parameter int unsigned COORD_WIDTH  = caalu_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_STAGES = caalu_pkg::ANGLE_STAGES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  caalu_pkg::in_t   item_i,
  output logic             busy_o,
  output logic             done_o,
  output caalu_pkg::out_t  result_o
);
  import caalu_pkg::*;

  localparam int unsigned RW      = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int unsigned EXT_SH  = FIELD_W - RW;
  localparam int unsigned LATENCY = 144 + ANGLE_STAGES;
  localparam int unsigned NDA_W   = WIDE_W - 1;
  localparam int unsigned D1A_W   = 32 + SIDE_W;
  localparam int unsigned SNA_W   = ANGLE_W + SIDE_W;
  localparam logic signed [WIDE_W-1:0] LEN_MAX = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] LEN_MIN = -64'sd2147483648;
  localparam logic signed [WIDE_W-1:0] HALF_LSB = 64'sd134217728;

  // Take the low coordinate bits and sign-extend them.
  function automatic logic signed [FIELD_W-1:0] read_coord(input logic [FIELD_W-1:0] raw);
    logic [FIELD_W-1:0] up;
    up = raw << EXT_SH;
    return $signed(up) >>> EXT_SH;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [5:0] lead33(input logic [32:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Scale one component so the largest one lands in [2^29, 2^30).
  function automatic logic signed [VEC_W-1:0] norm(input logic signed [32:0] v,
                                                   input logic [5:0] p);
    logic [32:0] m;
    logic [32:0] a;
    m = mag33(v);
    if (p >= 6'd30) begin
      a = m >> (p - 6'd29);
    end else begin
      a = m << (6'd29 - p);
    end
    return v[32] ? $signed(VEC_W'(-a)) : $signed(VEC_W'(a));
  endfunction

  assign busy_o = 1'b0;

  // Stage 1: register the coordinates and form the chord.
  logic                      vld1_q;
  logic signed [32:0]        d1_q [3];
  logic signed [32:0]        c1_q [3];
  logic signed [FIELD_W-1:0] rad1_q;
  logic                      ccw1_q;

  always_ff @(posedge clk_i) begin
    d1_q[0] <= 33'(read_coord(item_i.dir_x));
    d1_q[1] <= 33'(read_coord(item_i.dir_y));
    d1_q[2] <= 33'(read_coord(item_i.dir_z));
    c1_q[0] <= 33'(read_coord(item_i.end_x)) - 33'(read_coord(item_i.start_x));
    c1_q[1] <= 33'(read_coord(item_i.end_y)) - 33'(read_coord(item_i.start_y));
    c1_q[2] <= 33'(read_coord(item_i.end_z)) - 33'(read_coord(item_i.start_z));
    rad1_q  <= read_coord(item_i.radius);
    ccw1_q  <= item_i.counter_clockwise;
  end

  // Stage 2: largest magnitude of each vector and the zero-length check.
  logic              vld2_q;
  logic signed [32:0] d2_q [3];
  logic signed [32:0] c2_q [3];
  logic [32:0]        md2_q;
  logic [32:0]        mc2_q;
  logic               inv2_q;
  logic signed [FIELD_W-1:0] rad2_q;
  logic               ccw2_q;
  logic [32:0]        md_d;
  logic [32:0]        mc_d;

  always_comb begin
    md_d = mag33(d1_q[0]);
    mc_d = mag33(c1_q[0]);
    for (int i = 1; i < 3; i++) begin
      if (mag33(d1_q[i]) > md_d) begin
        md_d = mag33(d1_q[i]);
      end
      if (mag33(c1_q[i]) > mc_d) begin
        mc_d = mag33(c1_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q   <= d1_q;
    c2_q   <= c1_q;
    md2_q  <= md_d;
    mc2_q  <= mc_d;
    inv2_q <= (md_d == '0) || (mc_d == '0);
    rad2_q <= rad1_q;
    ccw2_q <= ccw1_q;
  end

  // Stage 3: position of the leading one.
  logic               vld3_q;
  logic signed [32:0] d3_q [3];
  logic signed [32:0] c3_q [3];
  logic [5:0]         pd3_q;
  logic [5:0]         pc3_q;
  logic               inv3_q;
  logic signed [FIELD_W-1:0] rad3_q;
  logic               ccw3_q;

  always_ff @(posedge clk_i) begin
    d3_q   <= d2_q;
    c3_q   <= c2_q;
    pd3_q  <= lead33(md2_q);
    pc3_q  <= lead33(mc2_q);
    inv3_q <= inv2_q;
    rad3_q <= rad2_q;
    ccw3_q <= ccw2_q;
  end

  // Stage 4: normalised vectors.
  logic                    vld4_q;
  logic signed [VEC_W-1:0] dn4_q [3];
  logic signed [VEC_W-1:0] cn4_q [3];
  logic                    inv4_q;
  logic signed [FIELD_W-1:0] rad4_q;
  logic                    ccw4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dn4_q[i] <= norm(d3_q[i], pd3_q);
      cn4_q[i] <= norm(c3_q[i], pc3_q);
    end
    inv4_q <= inv3_q;
    rad4_q <= rad3_q;
    ccw4_q <= ccw3_q;
  end

  // Stage 5: the nine component products.
  logic               vld5_q;
  logic signed [61:0] pdot5_q [3];
  logic signed [61:0] pnd5_q [3];
  logic signed [61:0] pnc5_q [3];
  logic               inv5_q;
  logic signed [FIELD_W-1:0] rad5_q;
  logic               ccw5_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pdot5_q[i] <= 62'(dn4_q[i]) * 62'(cn4_q[i]);
      pnd5_q[i]  <= 62'(dn4_q[i]) * 62'(dn4_q[i]);
      pnc5_q[i]  <= 62'(cn4_q[i]) * 62'(cn4_q[i]);
    end
    inv5_q <= inv4_q;
    rad5_q <= rad4_q;
    ccw5_q <= ccw4_q;
  end

  // Stage 6: dot product and squared norms.
  logic              vld6_q;
  logic [NDA_W-1:0]  dmag6_q;
  logic [WIDE_W-1:0] nd6_q;
  logic [WIDE_W-1:0] nc6_q;
  side_t             side6_q;
  logic signed [WIDE_W-1:0] dot_d;

  always_comb begin
    dot_d = WIDE_W'(pdot5_q[0]) + WIDE_W'(pdot5_q[1]) + WIDE_W'(pdot5_q[2]);
  end

  always_ff @(posedge clk_i) begin
    dmag6_q <= dot_d[WIDE_W-1] ? NDA_W'(-dot_d) : NDA_W'(dot_d);
    nd6_q   <= WIDE_W'(pnd5_q[0]) + WIDE_W'(pnd5_q[1]) + WIDE_W'(pnd5_q[2]);
    nc6_q   <= WIDE_W'(pnc5_q[0]) + WIDE_W'(pnc5_q[1]) + WIDE_W'(pnc5_q[2]);
    side6_q.radius  <= rad5_q;
    side6_q.ccw     <= ccw5_q;
    side6_q.inv     <= inv5_q;
    side6_q.dot_neg <= dot_d[WIDE_W-1];
  end

  // Square root chains for both norms, one result bit per cell.
  logic              ndv [ROOT_STEPS+1];
  logic [WIDE_W-1:0] ndr [ROOT_STEPS+1];
  logic [WIDE_W-1:0] ndt [ROOT_STEPS+1];
  logic [NDA_W-1:0]  nda [ROOT_STEPS+1];
  logic              ncv [ROOT_STEPS+1];
  logic [WIDE_W-1:0] ncr [ROOT_STEPS+1];
  logic [WIDE_W-1:0] nct [ROOT_STEPS+1];
  logic [SIDE_W-1:0] nca [ROOT_STEPS+1];

  assign ndv[0] = vld6_q;
  assign ndr[0] = nd6_q;
  assign ndt[0] = '0;
  assign nda[0] = dmag6_q;
  assign ncv[0] = vld6_q;
  assign ncr[0] = nc6_q;
  assign nct[0] = '0;
  assign nca[0] = side6_q;

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_norm_root
    caalu_sqrt_cell #(.K(ROOT_STEPS - 1 - j), .AUX_W(NDA_W)) u_nd (
      .clk_i, .rst_ni,
      .vld_i(ndv[j]), .rad_i(ndr[j]), .root_i(ndt[j]), .aux_i(nda[j]),
      .vld_o(ndv[j+1]), .rad_o(ndr[j+1]), .root_o(ndt[j+1]), .aux_o(nda[j+1])
    );
    caalu_sqrt_cell #(.K(ROOT_STEPS - 1 - j), .AUX_W(SIDE_W)) u_nc (
      .clk_i, .rst_ni,
      .vld_i(ncv[j]), .rad_i(ncr[j]), .root_i(nct[j]), .aux_i(nca[j]),
      .vld_o(ncv[j+1]), .rad_o(ncr[j+1]), .root_o(nct[j+1]), .aux_o(nca[j+1])
    );
  end

  // First divider: |dot| / |D|.
  logic              d1v [DIV1_STEPS+1];
  logic [WIDE_W-1:0] d1r [DIV1_STEPS+1];
  logic [31:0]       d1s [DIV1_STEPS+1];
  logic [QUO_W-1:0]  d1q [DIV1_STEPS+1];
  logic [D1A_W-1:0]  d1a [DIV1_STEPS+1];

  assign d1v[0] = ndv[ROOT_STEPS] && ncv[ROOT_STEPS];
  assign d1r[0] = WIDE_W'(nda[ROOT_STEPS]);
  assign d1s[0] = ndt[ROOT_STEPS][31:0];
  assign d1q[0] = '0;
  assign d1a[0] = {nct[ROOT_STEPS][31:0], nca[ROOT_STEPS]};

  for (genvar j = 0; j < DIV1_STEPS; j++) begin : g_div1
    caalu_div_cell #(.SH(DIV1_STEPS - 1 - j), .AUX_W(D1A_W)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(d1v[j]), .rem_i(d1r[j]), .dvs_i(d1s[j]), .quo_i(d1q[j]), .aux_i(d1a[j]),
      .vld_o(d1v[j+1]), .rem_o(d1r[j+1]), .dvs_o(d1s[j+1]), .quo_o(d1q[j+1]),
      .aux_o(d1a[j+1])
    );
  end

  // Second divider: (quotient << 30) / |C|, giving the cosine magnitude.
  logic              d2v [DIV2_STEPS+1];
  logic [WIDE_W-1:0] d2r [DIV2_STEPS+1];
  logic [31:0]       d2s [DIV2_STEPS+1];
  logic [QUO_W-1:0]  d2q [DIV2_STEPS+1];
  logic [SIDE_W-1:0] d2a [DIV2_STEPS+1];

  assign d2v[0] = d1v[DIV1_STEPS];
  assign d2r[0] = WIDE_W'(d1q[DIV1_STEPS]) << 30;
  assign d2s[0] = d1a[DIV1_STEPS][D1A_W-1:SIDE_W];
  assign d2q[0] = '0;
  assign d2a[0] = d1a[DIV1_STEPS][SIDE_W-1:0];

  for (genvar j = 0; j < DIV2_STEPS; j++) begin : g_div2
    caalu_div_cell #(.SH(DIV2_STEPS - 1 - j), .AUX_W(SIDE_W)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(d2v[j]), .rem_i(d2r[j]), .dvs_i(d2s[j]), .quo_i(d2q[j]), .aux_i(d2a[j]),
      .vld_o(d2v[j+1]), .rem_o(d2r[j+1]), .dvs_o(d2s[j+1]), .quo_o(d2q[j+1]),
      .aux_o(d2a[j+1])
    );
  end

  // Cap the cosine at one, square it, and form the sine radicand.
  logic               vldc_q, vlds_q, vldv_q;
  logic [ANGLE_W-1:0] cmc_q, cms_q, cmv_q;
  logic [61:0]        cmsq_q;
  logic [WIDE_W-1:0]  rv_q;
  side_t              sidec_q, sides_q, sidev_q;

  always_ff @(posedge clk_i) begin
    cmc_q   <= (d2q[DIV2_STEPS] > QUO_W'(ONE_Q30)) ? ONE_Q30 : d2q[DIV2_STEPS][ANGLE_W-1:0];
    sidec_q <= d2a[DIV2_STEPS];
    cms_q   <= cmc_q;
    cmsq_q  <= 62'(cmc_q) * 62'(cmc_q);
    sides_q <= sidec_q;
    cmv_q   <= cms_q;
    rv_q    <= (WIDE_W'(1) << 60) - WIDE_W'(cmsq_q);
    sidev_q <= sides_q;
  end

  // Sine root chain.
  logic              snv [ROOT_STEPS+1];
  logic [WIDE_W-1:0] snr [ROOT_STEPS+1];
  logic [WIDE_W-1:0] snt [ROOT_STEPS+1];
  logic [SNA_W-1:0]  sna [ROOT_STEPS+1];

  assign snv[0] = vldv_q;
  assign snr[0] = rv_q;
  assign snt[0] = '0;
  assign sna[0] = {cmv_q, sidev_q};

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_sin_root
    caalu_sqrt_cell #(.K(ROOT_STEPS - 1 - j), .AUX_W(SNA_W)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(snv[j]), .rad_i(snr[j]), .root_i(snt[j]), .aux_i(sna[j]),
      .vld_o(snv[j+1]), .rad_o(snr[j+1]), .root_o(snt[j+1]), .aux_o(sna[j+1])
    );
  end

  // Quarter-turn pre-rotation when the cosine is negative.
  logic                     vldp_q;
  logic signed [CORD_W-1:0] xp_q, yp_q;
  logic signed [ZED_W-1:0]  zp_q;
  side_t                    sidep_q;
  logic [ANGLE_W-1:0]       cm_p;
  logic [ANGLE_W-1:0]       sin_p;
  side_t                    side_p;

  always_comb begin
    cm_p   = sna[ROOT_STEPS][SNA_W-1:SIDE_W];
    side_p = sna[ROOT_STEPS][SIDE_W-1:0];
    sin_p  = snt[ROOT_STEPS][ANGLE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    sidep_q <= side_p;
    if (side_p.dot_neg && (cm_p != '0)) begin
      xp_q <= $signed(CORD_W'(sin_p));
      yp_q <= $signed(CORD_W'(cm_p));
      zp_q <= $signed(ZED_W'(HALF_PI_Q28));
    end else begin
      xp_q <= $signed(CORD_W'(cm_p));
      yp_q <= $signed(CORD_W'(sin_p));
      zp_q <= '0;
    end
  end

  // CORDIC chain.
  logic                     crv [ANGLE_STAGES+1];
  logic signed [CORD_W-1:0] crx [ANGLE_STAGES+1];
  logic signed [CORD_W-1:0] cry [ANGLE_STAGES+1];
  logic signed [ZED_W-1:0]  crz [ANGLE_STAGES+1];
  logic [SIDE_W-1:0]        cra [ANGLE_STAGES+1];

  assign crv[0] = vldp_q;
  assign crx[0] = xp_q;
  assign cry[0] = yp_q;
  assign crz[0] = zp_q;
  assign cra[0] = sidep_q;

  for (genvar j = 0; j < ANGLE_STAGES; j++) begin : g_cordic
    caalu_cordic_cell #(.STAGE(j), .AUX_W(SIDE_W)) u_cell (
      .clk_i, .rst_ni,
      .vld_i(crv[j]), .x_i(crx[j]), .y_i(cry[j]), .z_i(crz[j]), .aux_i(cra[j]),
      .vld_o(crv[j+1]), .x_o(crx[j+1]), .y_o(cry[j+1]), .z_o(crz[j+1]),
      .aux_o(cra[j+1])
    );
  end

  // Clamp beta and form the arc angle.
  logic               vldz_q;
  logic [ANGLE_W-1:0] angz_q;
  side_t              sidez_q;
  side_t              side_z;
  logic signed [ZED_W-1:0] zf;
  logic [ANGLE_W-1:0] beta;

  always_comb begin
    side_z = cra[ANGLE_STAGES];
    zf     = crz[ANGLE_STAGES];
    if (zf[ZED_W-1]) begin
      beta = '0;
    end else if (zf > $signed(ZED_W'(PI_Q28))) begin
      beta = PI_Q28;
    end else begin
      beta = zf[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sidez_q <= side_z;
    if (side_z.inv) begin
      angz_q <= '0;
    end else if (side_z.ccw) begin
      angz_q <= TWO_PI_Q28 - (beta << 1);
    end else begin
      angz_q <= beta << 1;
    end
  end

  // Multiply by the radius.
  logic                     vldm_q;
  logic signed [WIDE_W-1:0] prodm_q;
  logic [ANGLE_W-1:0]       angm_q;
  logic                     invm_q;

  always_ff @(posedge clk_i) begin
    prodm_q <= WIDE_W'(sidez_q.radius) * $signed(WIDE_W'(angz_q));
    angm_q  <= angz_q;
    invm_q  <= sidez_q.inv;
  end

  // Round, saturate and present the result.
  logic                     done_q;
  out_t                     result_q;
  logic signed [WIDE_W-1:0] len_w;

  always_comb begin
    len_w = (prodm_q + HALF_LSB) >>> 28;
  end

  always_ff @(posedge clk_i) begin
    result_q.invalid   <= invm_q;
    result_q.arc_angle <= invm_q ? '0 : angm_q;
    if (invm_q) begin
      result_q.arc_length <= '0;
    end else if (len_w > LEN_MAX) begin
      result_q.arc_length <= LEN_MAX[31:0];
    end else if (len_w < LEN_MIN) begin
      result_q.arc_length <= LEN_MIN[31:0];
    end else begin
      result_q.arc_length <= len_w[31:0];
    end
  end

  // Valid bits of the explicit pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vldc_q <= 1'b0;
      vlds_q <= 1'b0;
      vldv_q <= 1'b0;
      vldp_q <= 1'b0;
      vldz_q <= 1'b0;
      vldm_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld1_q <= start_i && !busy_o;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vldc_q <= d2v[DIV2_STEPS];
      vlds_q <= vldc_q;
      vldv_q <= vlds_q;
      vldp_q <= snv[ROOT_STEPS];
      vldz_q <= crv[ANGLE_STAGES];
      vldm_q <= vldz_q;
      done_q <= vldm_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Checks on the result stream and on item entry.
  `CAALU_ASSERT_IMPLIES(a_invalid_zero, done_o && result_o.invalid,
    (result_o.arc_angle == '0) && (result_o.arc_length == '0), "invalid result not zeroed")
  `CAALU_ASSERT_IMPLIES(a_angle_range, done_o,
    result_o.arc_angle <= TWO_PI_Q28, "arc angle beyond a full turn")
  `CAALU_ASSERT_IMPLIES(a_latency, done_o,
    $past(start_i && !busy_o, LATENCY), "result without an item accepted at the set latency")
  `CAALU_ASSERT_NEXT(a_enter, start_i && !busy_o, vld1_q, "accepted item did not enter the pipeline")

endmodule

// File: hw/rtl/caalu_sqrt_cell.sv
// One result bit of a floor square root; K is the bit position it decides.
module caalu_sqrt_cell #(
  parameter int unsigned K     = 0,
  parameter int unsigned AUX_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [caalu_pkg::WIDE_W-1:0]  rad_i,
  input  logic [caalu_pkg::WIDE_W-1:0]  root_i,
  input  logic [AUX_W-1:0]              aux_i,
  output logic                          vld_o,
  output logic [caalu_pkg::WIDE_W-1:0]  rad_o,
  output logic [caalu_pkg::WIDE_W-1:0]  root_o,
  output logic [AUX_W-1:0]              aux_o
);
  import caalu_pkg::*;

  localparam logic [WIDE_W-1:0] BIT = WIDE_W'(1) << (2 * K);

  logic [WIDE_W-1:0] trial;
  logic              take;

  // Trial subtraction of the partial root plus this step's bit.
  always_comb begin
    trial = root_i + BIT;
    take  = (rad_i >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    aux_o <= aux_i;
    if (take) begin
      rad_o  <= rad_i - trial;
      root_o <= (root_i >> 1) + BIT;
    end else begin
      rad_o  <= rad_i;
      root_o <= root_i >> 1;
    end
  end

endmodule

// File: hw/rtl/caalu_div_cell.sv
// One quotient bit of a restoring divider; SH is the divisor shift it tries.
module caalu_div_cell #(
  parameter int unsigned SH    = 0,
  parameter int unsigned AUX_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [caalu_pkg::WIDE_W-1:0]  rem_i,
  input  logic [31:0]                   dvs_i,
  input  logic [caalu_pkg::QUO_W-1:0]   quo_i,
  input  logic [AUX_W-1:0]              aux_i,
  output logic                          vld_o,
  output logic [caalu_pkg::WIDE_W-1:0]  rem_o,
  output logic [31:0]                   dvs_o,
  output logic [caalu_pkg::QUO_W-1:0]   quo_o,
  output logic [AUX_W-1:0]              aux_o
);
  import caalu_pkg::*;

  logic [WIDE_W+1:0] diff;
  logic              take;

  // The remainder is below 2^64, so the sign of the wide difference decides.
  always_comb begin
    diff = {2'b00, rem_i} - ((WIDE_W + 2)'(dvs_i) << SH);
    take = !diff[WIDE_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    aux_o <= aux_i;
    dvs_o <= dvs_i;
    quo_o <= {quo_i[QUO_W-2:0], take};
    rem_o <= take ? diff[WIDE_W-1:0] : rem_i;
  end

endmodule

// File: hw/rtl/caalu_cordic_cell.sv
// One vectoring CORDIC rotation, driving y towards zero.
module caalu_cordic_cell #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned AUX_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                vld_i,
  input  logic signed [caalu_pkg::CORD_W-1:0] x_i,
  input  logic signed [caalu_pkg::CORD_W-1:0] y_i,
  input  logic signed [caalu_pkg::ZED_W-1:0]  z_i,
  input  logic [AUX_W-1:0]                    aux_i,
  output logic                                vld_o,
  output logic signed [caalu_pkg::CORD_W-1:0] x_o,
  output logic signed [caalu_pkg::CORD_W-1:0] y_o,
  output logic signed [caalu_pkg::ZED_W-1:0]  z_o,
  output logic [AUX_W-1:0]                    aux_o
);
  import caalu_pkg::*;

  localparam logic signed [ZED_W-1:0] ANG = $signed(stage_angle(STAGE));

  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;

  // Arithmetic shifts round towards minus infinity, as the rotation needs.
  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    aux_o <= aux_i;
    if (!y_i[CORD_W-1]) begin
      x_o <= x_i + dx;
      y_o <= y_i - dy;
      z_o <= z_i + ANG;
    end else begin
      x_o <= x_i - dx;
      y_o <= y_i + dy;
      z_o <= z_i - ANG;
    end
  end

endmodule

// File: tb/arc_checker.sv
module arc_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  caalu_pkg::in_t  item_i,
  input  logic            done_i,
  input  caalu_pkg::out_t result_i,
  output int              errors_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import caalu_pkg::*;

  out_t arc_expect_q[$];

  // Largest component magnitude of a vector.
  function automatic longint unsigned max_mag(input longint v[3]);
    longint unsigned m;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      if ((v[i] < 0 ? -v[i] : v[i]) > m) m = (v[i] < 0 ? -v[i] : v[i]);
    end
    return m;
  endfunction

  // Bring the largest magnitude into [2^29, 2^30), truncating on right shifts.
  function automatic void scale_vec(inout longint v[3]);
    longint unsigned m, a;
    int rs, ls;
    m = max_mag(v);
    rs = 0;
    ls = 0;
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      rs++;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      ls++;
    end
    for (int i = 0; i < 3; i++) begin
      a = ((v[i] < 0 ? -v[i] : v[i]) >> rs) << ls;
      v[i] = (v[i] < 0) ? -longint'(a) : longint'(a);
    end
  endfunction

  // Floor square root of a 64-bit value.
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring rotation giving atan2(s, c) in Q4.28, clamped to [0, pi].
  function automatic longint half_angle(input longint c, input longint s);
    longint x, y, z, dx, dy;
    x = c;
    y = s;
    z = 0;
    if (c < 0) begin
      x = s;
      y = -c;
      z = HALF_PI_Q28;
    end
    for (int i = 0; i < ANGLE_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(stage_angle(i));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(stage_angle(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(PI_Q28)) z = PI_Q28;
    return z;
  endfunction

  function automatic out_t predict_arc(input in_t it);
    longint d[3], c[3];
    longint dotp, beta, ang, len, sn;
    longint unsigned nd, nc, q, cm;
    out_t r;
    d[0] = it.dir_x;
    d[1] = it.dir_y;
    d[2] = it.dir_z;
    c[0] = longint'(it.end_x) - longint'(it.start_x);
    c[1] = longint'(it.end_y) - longint'(it.start_y);
    c[2] = longint'(it.end_z) - longint'(it.start_z);
    r = '0;
    r.invalid = 1'b1;
    if ((d[0] | d[1] | d[2]) == 0 || (c[0] | c[1] | c[2]) == 0) return r;
    scale_vec(d);
    scale_vec(c);
    dotp = 0;
    nd = 0;
    nc = 0;
    for (int i = 0; i < 3; i++) begin
      dotp += d[i] * c[i];
      nd += d[i] * d[i];
      nc += c[i] * c[i];
    end
    nd = root_floor(nd);
    nc = root_floor(nc);
    q = (dotp < 0 ? -dotp : dotp) / nd;
    cm = (q << 30) / nc;
    if (cm > ONE_Q30) cm = ONE_Q30;
    sn = root_floor((64'd1 << 60) - cm * cm);
    beta = half_angle(dotp < 0 ? -longint'(cm) : longint'(cm), sn);
    ang = it.counter_clockwise ? longint'(TWO_PI_Q28) - 2 * beta : 2 * beta;
    len = (longint'(it.radius) * ang + (64'sd1 <<< 27)) >>> 28;
    if (len > 64'sd2147483647) len = 64'sd2147483647;
    if (len < -64'sd2147483648) len = -64'sd2147483648;
    r.arc_angle = ang[30:0];
    r.arc_length = len[31:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  assign pending_o = arc_expect_q.size();

  // Predict on each accepted item and compare each result with the oldest.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (start_i && !busy_i) arc_expect_q.push_back(predict_arc(item_i));
      if (done_i) begin
        if (arc_expect_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result_i);
          errors_o <= errors_o + 1;
        end else begin
          e = arc_expect_q.pop_front();
          if (e.arc_angle !== result_i.arc_angle || e.arc_length !== result_i.arc_length
              || e.invalid !== result_i.invalid) begin
            $display("%0t: expected angle %0d length %0d invalid %0b, got %0d %0d %0b",
                     $time, e.arc_angle, e.arc_length, e.invalid, result_i.arc_angle,
                     result_i.arc_length, result_i.invalid);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import caalu_pkg::*;

  localparam int LATENCY = 144 + ANGLE_STAGES_DEF;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  in_t  item_i = '0;
  logic busy_o, done_o;
  out_t result_o;
  int   errors, pending, idle_cycles;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  circular_arc_angle_length_unit DUT (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .done_o, .result_o
  );

  arc_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .item_i, .done_i(done_o),
    .result_i(result_o), .errors_o(errors), .pending_o(pending)
  );

  // Watchdog on cycles with no item or result accepted.
  always @(posedge clk_i) begin
    if (start_i && !busy_o || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("circular_arc_angle_length_unit test failed");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 8) - 4;
      3: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_arc();
    in_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom, 1'b0};
    it.dir_x = pick_coord();
    it.dir_y = pick_coord();
    it.dir_z = pick_coord();
    it.start_x = pick_coord();
    it.start_y = pick_coord();
    it.start_z = pick_coord();
    it.end_x = pick_coord();
    it.end_y = pick_coord();
    it.end_z = pick_coord();
    it.radius = pick_coord();
    it.counter_clockwise = $urandom_range(0, 1);
    // Now and then collapse the direction or the chord, or set the chord to plus or minus the direction.
    case ($urandom_range(0, 19))
      0: {it.dir_x, it.dir_y, it.dir_z} = '0;
      1: {it.end_x, it.end_y, it.end_z} = {it.start_x, it.start_y, it.start_z};
      2: {it.end_x, it.end_y, it.end_z} = {it.start_x + it.dir_x, it.start_y + it.dir_y,
                                           it.start_z + it.dir_z};
      3: {it.end_x, it.end_y, it.end_z} = {it.start_x - it.dir_x, it.start_y - it.dir_y,
                                           it.start_z - it.dir_z};
      default: ;
    endcase
    return it;
  endfunction

  // Present one item and hold it until accepted, then idle for a random gap.
  task automatic send_item(input in_t it);
    int gap;
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
        : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic in_t arc_item(input int dx, dy, dz, sx, sy, sz, ex, ey, ez, r,
                                   input bit ccw);
    in_t it;
    it = '{dx, dy, dz, sx, sy, sz, ex, ey, ez, r, ccw};
    return it;
  endfunction

  initial begin
    int waited;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: zero direction, zero chord, parallel, opposite, square, extremes.
    send_item(arc_item(0, 0, 0, 0, 0, 0, 65536, 0, 0, 65536, 0));
    send_item(arc_item(65536, 0, 0, 5, 5, 5, 5, 5, 5, 65536, 1));
    send_item(arc_item(65536, 0, 0, 0, 0, 0, 65536, 0, 0, 65536, 0));
    send_item(arc_item(65536, 0, 0, 0, 0, 0, 65536, 0, 0, 65536, 1));
    send_item(arc_item(65536, 0, 0, 0, 0, 0, -65536, 0, 0, 65536, 0));
    send_item(arc_item(65536, 0, 0, 0, 0, 0, -65536, 0, 0, -65536, 1));
    send_item(arc_item(0, 65536, 0, 0, 0, 0, 65536, 65536, 0, 131072, 0));
    send_item(arc_item(0, 65536, 0, 0, 0, 0, 65536, 65536, 0, 131072, 1));
    send_item(arc_item(3, 3, 3, 0, 0, 0, 7, 7, 7, 65536, 0));
    send_item(arc_item(1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
    send_item(arc_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 1));
    send_item(arc_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 0));
    send_item(arc_item(-1, -1, -1, 0, 0, 0, 1, 1, 1, 32'h80000000, 1));
    send_item(arc_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       32'hffffffff, 32'hffffffff, 0, 0, 0, 32'hffffffff, 1));
    send_item(arc_item(1, 2, 3, 0, 0, 0, 3, 2, 1, 32'h7fffffff, 0));

    // Random items.
    for (int n = 0; n < 1850; n++) send_item(random_arc());
    start_i <= 1'b0;

    // Drain the pipeline.
    waited = 0;
    while (pending != 0 && waited < 4 * LATENCY) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("circular_arc_angle_length_unit test passed");
    end else begin
      $display("circular_arc_angle_length_unit test failed");
    end
    $finish;
  end
endmodule
